@@ design/hgd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the hand gesture drive mapper: widths, mode and hand-signal codes,
// configuration register indexes, reciprocal constants and the output saturation.
// Depends on nothing; used by design/hand_gesture_drive_mapper.sv.
package hgd_pkg;

    // Width of the signed palm positions on the input stream.
    localparam int POS_WIDTH = 12;

    // Field widths fixed by the interface.
    localparam int ZONE_W     = 11;
    localparam int REP_W      = 16;
    localparam int CMD_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Internal signed arithmetic width: holds any magnitude, zone or command.
    localparam int CALC_W = ((POS_WIDTH > CMD_W) ? POS_WIDTH : CMD_W) + 2;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((2 * POS_WIDTH + 1 + 7) / 8) * 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = ((2 * CMD_W + 1 + 2 + 7) / 8) * 8;

    // Reciprocal multipliers for the constant divides by 5 and by 10.
    localparam int MUL_W       = 16;
    localparam int DIV5_MUL    = 52429;
    localparam int DIV5_SHIFT  = 18;
    localparam int DIV10_MUL   = 52429;
    localparam int DIV10_SHIFT = 19;

    // Margin below the side full zone at which the steering edge case starts.
    localparam int EDGE_MARGIN = 3;

    typedef logic signed [CALC_W-1:0]    calc_t;
    typedef logic signed [POS_WIDTH-1:0] pos_t;
    typedef logic signed [CMD_W-1:0]     cmd_t;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_FREE = 2'd1,
        MODE_ROT  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        SIG_ABSENT  = 2'd0,
        SIG_GESTURE = 2'd1,
        SIG_PRESENT = 2'd2
    } hand_sig_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FWD_DEAD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_FULL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_DEAD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_FULL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_ANGLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 3'd6;

    // Register reset values.
    localparam logic [ZONE_W-1:0] FWD_DEAD_RST  = 11'd20;
    localparam logic [ZONE_W-1:0] FWD_FULL_RST  = 11'd120;
    localparam logic [ZONE_W-1:0] SIDE_DEAD_RST = 11'd20;
    localparam logic [ZONE_W-1:0] SIDE_FULL_RST = 11'd120;
    localparam logic [ZONE_W-1:0] TOP_SPEED_RST = 11'd100;
    localparam logic [ZONE_W-1:0] TOP_ANGLE_RST = 11'd10;
    localparam logic [REP_W-1:0]  REPEAT_RST    = 16'd10;

    // Saturate a wide signed value to the command range.
    function automatic cmd_t sat_cmd(input calc_t v);
        calc_t hi;
        calc_t lo;
        hi = calc_t'((2 ** (CMD_W - 1)) - 1);
        lo = -calc_t'(2 ** (CMD_W - 1));
        if (v > hi)
        begin
            return cmd_t'(hi);
        end
        else if (v < lo)
        begin
            return cmd_t'(lo);
        end
        return cmd_t'(v);
    endfunction

endpackage

@@ design/hand_gesture_drive_mapper.sv @@
`timescale 1ns / 1ps
// Top level of the hand gesture drive mapper: input register, mode machine,
// speed and angle mapping, repeat filter and output register in one pass.
// Depends on design/hgd_pkg.sv.
//
//  Channel   Direction  Handshake              Payload
//  s_*       in         s_tvalid / s_tready    tdata: palm_x, palm_z, palm_up
//                                              tuser: any_hand, right_seen
//  m_*       out        m_tvalid / m_tready    tdata: speed_cmd, angle_cmd,
//                                              straight, mode_after
//  cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle unless a result is stalled: an accepted item is held in the
// input register, then the mode machine and mapping update the state and load the
// output register, so a result is valid once its item leaves the input register.
// An item with no result leaves the input register without loading the output register.
// s_tready drops only while a result waits in the output register with
// m_tready low and a new item waits behind it. cfg_ready is always high.
// rst_n clears all state and restores the register defaults.
module hand_gesture_drive_mapper
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata from bit 0: palm_x, palm_z, palm_up, zero fill.
    input  logic [hgd_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser from bit 0: any_hand, right_seen.
    input  logic [hgd_pkg::S_TUSER_W-1:0]   s_tuser,
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata from bit 0: speed_cmd, angle_cmd, straight, mode_after, zero fill.
    output logic [hgd_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hgd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hgd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PW   = hgd_pkg::POS_WIDTH;
    localparam int PRDW = hgd_pkg::POS_WIDTH + hgd_pkg::MUL_W;
    localparam int Q5W  = PRDW - hgd_pkg::DIV5_SHIFT;
    localparam int Q10W = PRDW - hgd_pkg::DIV10_SHIFT;

    // Configuration registers.
    logic [hgd_pkg::ZONE_W-1:0] fwd_dead_reg;
    logic [hgd_pkg::ZONE_W-1:0] fwd_full_reg;
    logic [hgd_pkg::ZONE_W-1:0] side_dead_reg;
    logic [hgd_pkg::ZONE_W-1:0] side_full_reg;
    logic [hgd_pkg::ZONE_W-1:0] top_speed_reg;
    logic [hgd_pkg::ZONE_W-1:0] top_angle_reg;
    logic [hgd_pkg::REP_W-1:0]  repeat_limit_reg;

    // Input register.
    logic                in_valid_reg;
    logic                in_any_reg;
    logic                in_right_reg;
    hgd_pkg::pos_t       in_x_reg;
    hgd_pkg::pos_t       in_z_reg;
    logic                in_up_reg;

    // Tracking and mode state.
    hgd_pkg::mode_t      mode_reg;
    hgd_pkg::mode_t      mode_next;
    hgd_pkg::pos_t       held_x_reg;
    hgd_pkg::pos_t       held_x_next;
    hgd_pkg::pos_t       held_z_reg;
    hgd_pkg::pos_t       held_z_next;
    logic                hand_reg;
    logic                hand_next;
    logic                palm_now_reg;
    logic                palm_now_next;
    logic                palm_before_reg;
    logic                palm_before_next;
    hgd_pkg::calc_t      last_speed_reg;
    hgd_pkg::calc_t      last_speed_next;
    hgd_pkg::calc_t      last_angle_reg;
    hgd_pkg::calc_t      last_angle_next;
    logic [hgd_pkg::REP_W-1:0] repeat_count_reg;
    logic [hgd_pkg::REP_W-1:0] repeat_count_next;

    // Output register.
    logic                m_valid_reg;
    hgd_pkg::cmd_t       speed_reg;
    hgd_pkg::cmd_t       speed_next;
    hgd_pkg::cmd_t       angle_reg;
    hgd_pkg::cmd_t       angle_next;
    logic                straight_reg;
    logic                straight_next;
    hgd_pkg::mode_t      mode_out_reg;

    // Compute stage signals.
    logic                adv;
    logic                in_fire;
    logic                emit;
    logic                right;
    hgd_pkg::hand_sig_t  hand_sig;
    hgd_pkg::calc_t      hx;
    hgd_pkg::calc_t      hz;
    hgd_pkg::calc_t      ax;
    hgd_pkg::calc_t      az;
    hgd_pkg::calc_t      qa;
    hgd_pkg::calc_t      q_dead;
    hgd_pkg::calc_t      q_full;
    hgd_pkg::calc_t      q_val;
    logic [PRDW-1:0]     prod5;
    logic [Q5W-1:0]      q5;
    hgd_pkg::calc_t      side_diff;
    logic [PRDW-1:0]     prod10;
    logic [Q10W-1:0]     q10;
    hgd_pkg::calc_t      sdz;
    hgd_pkg::calc_t      sfz;
    hgd_pkg::calc_t      spd;
    hgd_pkg::calc_t      ang;
    logic                lin;
    logic                same_cmd;
    logic                repeat_send;

    assign in_fire   = s_tvalid && s_tready;
    assign adv       = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || adv;
    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_dead_reg     <= hgd_pkg::FWD_DEAD_RST;
            fwd_full_reg     <= hgd_pkg::FWD_FULL_RST;
            side_dead_reg    <= hgd_pkg::SIDE_DEAD_RST;
            side_full_reg    <= hgd_pkg::SIDE_FULL_RST;
            top_speed_reg    <= hgd_pkg::TOP_SPEED_RST;
            top_angle_reg    <= hgd_pkg::TOP_ANGLE_RST;
            repeat_limit_reg <= hgd_pkg::REPEAT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hgd_pkg::REG_FWD_DEAD:  fwd_dead_reg     <= cfg_data[hgd_pkg::ZONE_W-1:0];
                hgd_pkg::REG_FWD_FULL:  fwd_full_reg     <= cfg_data[hgd_pkg::ZONE_W-1:0];
                hgd_pkg::REG_SIDE_DEAD: side_dead_reg    <= cfg_data[hgd_pkg::ZONE_W-1:0];
                hgd_pkg::REG_SIDE_FULL: side_full_reg    <= cfg_data[hgd_pkg::ZONE_W-1:0];
                hgd_pkg::REG_TOP_SPEED: top_speed_reg    <= cfg_data[hgd_pkg::ZONE_W-1:0];
                hgd_pkg::REG_TOP_ANGLE: top_angle_reg    <= cfg_data[hgd_pkg::ZONE_W-1:0];
                hgd_pkg::REG_REPEAT:    repeat_limit_reg <= cfg_data[hgd_pkg::REP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register: payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_x_reg     <= s_tdata[PW-1:0];
            in_z_reg     <= s_tdata[2*PW-1:PW];
            in_up_reg    <= s_tdata[2*PW];
            in_any_reg   <= s_tuser[0];
            in_right_reg <= s_tuser[1];
        end
    end

    // Frame reading: a right hand loads the held pose and shifts the palm history.
    always_comb
    begin
        right            = in_any_reg && in_right_reg;
        held_x_next      = right ? in_x_reg : held_x_reg;
        held_z_next      = right ? in_z_reg : held_z_reg;
        palm_before_next = right ? palm_now_reg : palm_before_reg;
        palm_now_next    = right ? in_up_reg : palm_now_reg;
        hand_next        = in_any_reg && (right || hand_reg);

        if (!hand_next)
        begin
            hand_sig = hgd_pkg::SIG_ABSENT;
        end
        else if (palm_before_next && !palm_now_next)
        begin
            hand_sig = hgd_pkg::SIG_GESTURE;
        end
        else
        begin
            hand_sig = hgd_pkg::SIG_PRESENT;
        end
    end

    // Magnitudes and the shared quantizer; rotation uses x and the side zones.
    always_comb
    begin
        hx = hgd_pkg::calc_t'(held_x_next);
        hz = hgd_pkg::calc_t'(held_z_next);
        ax = hx[hgd_pkg::CALC_W-1] ? -hx : hx;
        az = hz[hgd_pkg::CALC_W-1] ? -hz : hz;
        sdz = hgd_pkg::calc_t'(side_dead_reg);
        sfz = hgd_pkg::calc_t'(side_full_reg);

        if (mode_reg == hgd_pkg::MODE_ROT)
        begin
            qa     = ax;
            q_dead = sdz;
            q_full = sfz;
        end
        else
        begin
            qa     = az;
            q_dead = hgd_pkg::calc_t'(fwd_dead_reg);
            q_full = hgd_pkg::calc_t'(fwd_full_reg);
        end

        // qa - qa % 5 is five times the quotient by 5.
        prod5 = PRDW'(qa[PW-1:0]) * PRDW'(hgd_pkg::DIV5_MUL);
        q5    = prod5[PRDW-1:hgd_pkg::DIV5_SHIFT];

        q_val = '0;
        if (qa > q_full)
        begin
            q_val = hgd_pkg::calc_t'(top_speed_reg);
        end
        if (qa > q_dead && qa <= q_full)
        begin
            q_val = (hgd_pkg::calc_t'(q5) <<< 2) + hgd_pkg::calc_t'(q5)
                    - hgd_pkg::calc_t'(fwd_dead_reg);
        end

        // Steering: shrinks by one for every 10 mm past the side dead zone.
        side_diff = ax - sdz;
        prod10    = PRDW'(side_diff[PW-1:0]) * PRDW'(hgd_pkg::DIV10_MUL);
        q10       = prod10[PRDW-1:hgd_pkg::DIV10_SHIFT];
    end

    // Command selection per drive mode.
    always_comb
    begin
        if (mode_reg == hgd_pkg::MODE_ROT)
        begin
            lin = 1'b0;
            ang = '0;
            spd = hx[hgd_pkg::CALC_W-1] ? -q_val : q_val;
        end
        else
        begin
            lin = 1'b1;
            ang = '0;
            if (ax >= sfz - hgd_pkg::calc_t'(hgd_pkg::EDGE_MARGIN))
            begin
                ang = hgd_pkg::calc_t'(1);
                lin = 1'b0;
            end
            if (ax > sdz && ax < sfz)
            begin
                lin = 1'b0;
                ang = hgd_pkg::calc_t'(top_angle_reg) - hgd_pkg::calc_t'(q10);
            end
            spd = hz[hgd_pkg::CALC_W-1] ? -q_val : q_val;
            if (hx[hgd_pkg::CALC_W-1])
            begin
                ang = -ang;
            end
        end
    end

    // Mode machine, repeat filter and result selection.
    always_comb
    begin
        mode_next         = mode_reg;
        last_speed_next   = last_speed_reg;
        last_angle_next   = last_angle_reg;
        repeat_count_next = repeat_count_reg;
        emit              = 1'b0;
        speed_next        = '0;
        angle_next        = '0;
        straight_next     = 1'b1;
        same_cmd          = (spd == last_speed_reg) && (ang == last_angle_reg);
        repeat_send       = 1'b0;

        unique case (mode_reg)
            hgd_pkg::MODE_FREE, hgd_pkg::MODE_ROT:
            begin
                unique case (hand_sig)
                    hgd_pkg::SIG_ABSENT:
                    begin
                        mode_next = hgd_pkg::MODE_NONE;
                        emit      = 1'b1;
                    end
                    hgd_pkg::SIG_GESTURE:
                    begin
                        mode_next = (mode_reg == hgd_pkg::MODE_FREE) ?
                                    hgd_pkg::MODE_ROT : hgd_pkg::MODE_FREE;
                        emit      = 1'b1;
                    end
                    default:
                    begin
                        if (same_cmd)
                        begin
                            if (repeat_count_reg != '1)
                            begin
                                repeat_count_next = repeat_count_reg + 1'b1;
                                repeat_send = (repeat_count_next == repeat_limit_reg);
                            end
                        end
                        else
                        begin
                            last_speed_next   = spd;
                            last_angle_next   = ang;
                            repeat_count_next = '0;
                            repeat_send       = (repeat_limit_reg == '0);
                        end
                        emit          = repeat_send;
                        speed_next    = hgd_pkg::sat_cmd(-spd);
                        angle_next    = hgd_pkg::sat_cmd(-ang);
                        straight_next = lin;
                    end
                endcase
            end
            default:
            begin
                mode_next = (hand_sig == hgd_pkg::SIG_PRESENT) ?
                            hgd_pkg::MODE_FREE : hgd_pkg::MODE_NONE;
            end
        endcase
    end

    // State registers advance once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= hgd_pkg::MODE_NONE;
            held_x_reg       <= '0;
            held_z_reg       <= '0;
            hand_reg         <= 1'b0;
            palm_now_reg     <= 1'b0;
            palm_before_reg  <= 1'b0;
            last_speed_reg   <= '0;
            last_angle_reg   <= '0;
            repeat_count_reg <= '0;
        end
        else if (adv)
        begin
            mode_reg         <= mode_next;
            held_x_reg       <= held_x_next;
            held_z_reg       <= held_z_next;
            hand_reg         <= hand_next;
            palm_now_reg     <= palm_now_next;
            palm_before_reg  <= palm_before_next;
            last_speed_reg   <= last_speed_next;
            last_angle_reg   <= last_angle_next;
            repeat_count_reg <= repeat_count_next;
        end
    end

    // Output register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv && emit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register: payload.
    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            speed_reg    <= speed_next;
            angle_reg    <= angle_next;
            straight_reg <= straight_next;
            mode_out_reg <= mode_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = hgd_pkg::M_TDATA_W'({mode_out_reg, straight_reg, angle_reg, speed_reg});

    // A result that reports the no-hand mode is always the stop command.
    a_none_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && mode_out_reg == hgd_pkg::MODE_NONE) |->
        (speed_reg == '0 && angle_reg == '0 && straight_reg))
        else $error("no-hand result is not a stop command");

    // Rotation commands are never linear, except the stop sent on entry.
    a_rot_straight: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && mode_out_reg == hgd_pkg::MODE_ROT && straight_reg) |->
        (speed_reg == '0 && angle_reg == '0))
        else $error("linear rotation result with nonzero command");

    // The state only moves when an item is consumed.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(mode_reg) && $stable(repeat_count_reg) && $stable(hand_reg)))
        else $error("state changed without an item");

    // Input back-pressure only comes from a stalled result.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_valid_reg && !m_tready && in_valid_reg))
        else $error("input stalled without a waiting result");

    // Leaving a drive mode always produces a result.
    a_leave_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && mode_reg != hgd_pkg::MODE_NONE && mode_next != mode_reg) |=> m_valid_reg)
        else $error("mode change without a result");

endmodule

@@ dv/hand_gesture_drive_mapper_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for hand_gesture_drive_mapper: a queue-fed stream driver,
// a result monitor and a frame-level model of the mode machine, mapping and repeat filter.
// Depends on design/hgd_pkg.sv and design/hand_gesture_drive_mapper.sv.
module hand_gesture_drive_mapper_tb;

    localparam int IDLE_PCT     = 33;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_LIMIT = 200;
    localparam int TAIL_CYCLES  = 4;

    // Mapping constants of the drive rules.
    localparam int SPEED_STEP  = 5;
    localparam int ANGLE_STEP  = 10;
    localparam int EDGE_BAND   = 3;
    localparam int COUNT_MAX   = 65535;

    // Width of the junk placed above the zone bits of a register write.
    localparam int JUNK_W = hgd_pkg::CFG_DATA_W - hgd_pkg::ZONE_W;

    // No register lives at this index; a write to it must change nothing.
    localparam logic [hgd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam hgd_pkg::pos_t POS_MIN = hgd_pkg::pos_t'(1 << (hgd_pkg::POS_WIDTH - 1));
    localparam hgd_pkg::pos_t POS_MAX = ~POS_MIN;

    // One tracking frame, any_hand in the lowest bits.
    typedef struct packed {
        logic          palm_up;
        hgd_pkg::pos_t palm_z;
        hgd_pkg::pos_t palm_x;
        logic          right_seen;
        logic          any_hand;
    } frame_t;

    // One drive command as it sits in m_tdata, speed in the lowest bits.
    typedef struct packed {
        hgd_pkg::mode_t mode_after;
        logic           straight;
        hgd_pkg::cmd_t  angle_cmd;
        hgd_pkg::cmd_t  speed_cmd;
    } drive_cmd_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [hgd_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic [hgd_pkg::S_TUSER_W-1:0]   s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [hgd_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [hgd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [hgd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    hand_gesture_drive_mapper u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Frames waiting for the driver and commands waiting for the monitor.
    frame_t     frames_to_send[$];
    drive_cmd_t expected_cmds[$];
    frame_t     cur_frame;

    bit no_gaps = 1'b0;
    int errors = 0;
    int frames_in = 0;
    int cmds_checked = 0;
    int reg_writes = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    // Model copy of the registers.
    logic [hgd_pkg::ZONE_W-1:0] fwd_dead, fwd_full, side_dead, side_full, top_speed, top_angle;
    logic [hgd_pkg::REP_W-1:0]  rep_limit;

    // Model copy of the machine state.
    hgd_pkg::mode_t cur_mode;
    int             held_x, held_z;
    logic           hand_seen, palm_now, palm_before;
    int             last_speed, last_angle;
    int             rep_count;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void reset_model();
        fwd_dead    = hgd_pkg::FWD_DEAD_RST;
        fwd_full    = hgd_pkg::FWD_FULL_RST;
        side_dead   = hgd_pkg::SIDE_DEAD_RST;
        side_full   = hgd_pkg::SIDE_FULL_RST;
        top_speed   = hgd_pkg::TOP_SPEED_RST;
        top_angle   = hgd_pkg::TOP_ANGLE_RST;
        rep_limit   = hgd_pkg::REPEAT_RST;
        cur_mode    = hgd_pkg::MODE_NONE;
        held_x      = 0;
        held_z      = 0;
        hand_seen   = 1'b0;
        palm_now    = 1'b0;
        palm_before = 1'b0;
        last_speed  = 0;
        last_angle  = 0;
        rep_count   = 0;
    endfunction

    function automatic void apply_reg(input logic [hgd_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [hgd_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            hgd_pkg::REG_FWD_DEAD:  fwd_dead  = val[hgd_pkg::ZONE_W-1:0];
            hgd_pkg::REG_FWD_FULL:  fwd_full  = val[hgd_pkg::ZONE_W-1:0];
            hgd_pkg::REG_SIDE_DEAD: side_dead = val[hgd_pkg::ZONE_W-1:0];
            hgd_pkg::REG_SIDE_FULL: side_full = val[hgd_pkg::ZONE_W-1:0];
            hgd_pkg::REG_TOP_SPEED: top_speed = val[hgd_pkg::ZONE_W-1:0];
            hgd_pkg::REG_TOP_ANGLE: top_angle = val[hgd_pkg::ZONE_W-1:0];
            hgd_pkg::REG_REPEAT:    rep_limit = val[hgd_pkg::REP_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic hgd_pkg::cmd_t clamp_cmd(input int v);
        if (v > 2047)
        begin
            return hgd_pkg::cmd_t'(2047);
        end
        if (v < -2048)
        begin
            return hgd_pkg::cmd_t'(-2048);
        end
        return hgd_pkg::cmd_t'(v);
    endfunction

    // Commands go out negated; the mode field is the mode after the frame.
    function automatic drive_cmd_t make_cmd(input int spd, input int ang, input logic lin);
        drive_cmd_t c;
        c.speed_cmd  = clamp_cmd(-spd);
        c.angle_cmd  = clamp_cmd(-ang);
        c.straight   = lin;
        c.mode_after = cur_mode;
        return c;
    endfunction

    // Zone rules apply in order, later ones win; the step always takes off the
    // forward dead zone, even when the side zones bound the magnitude.
    function automatic int shaped_speed(input int mag, input int dz, input int fz);
        int v;
        v = 0;
        if (mag > fz)
        begin
            v = int'(top_speed);
        end
        if (mag > dz && mag <= fz)
        begin
            v = mag - (mag % SPEED_STEP) - int'(fwd_dead);
        end
        return v;
    endfunction

    // Advance the model by one frame; returns 1 when a command is sent.
    function automatic bit map_frame(input frame_t f, output drive_cmd_t cmd);
        hgd_pkg::hand_sig_t sig;
        int                 ax, az, spd, ang, sdz, sfz;
        logic               lin;
        cmd = '0;
        if (f.any_hand && f.right_seen)
        begin
            hand_seen   = 1'b1;
            held_x      = $signed(f.palm_x);
            held_z      = $signed(f.palm_z);
            palm_before = palm_now;
            palm_now    = f.palm_up;
        end
        if (!f.any_hand)
        begin
            hand_seen = 1'b0;
        end

        if (!hand_seen)
        begin
            sig = hgd_pkg::SIG_ABSENT;
        end
        else if (palm_before && !palm_now)
        begin
            sig = hgd_pkg::SIG_GESTURE;
        end
        else
        begin
            sig = hgd_pkg::SIG_PRESENT;
        end

        // Without a hand only a steady hand starts free running.
        if (cur_mode != hgd_pkg::MODE_FREE && cur_mode != hgd_pkg::MODE_ROT)
        begin
            cur_mode = (sig == hgd_pkg::SIG_PRESENT) ? hgd_pkg::MODE_FREE : hgd_pkg::MODE_NONE;
            return 1'b0;
        end

        // Losing the hand or flipping the palm stops the car; the filter is kept.
        if (sig != hgd_pkg::SIG_PRESENT)
        begin
            if (sig == hgd_pkg::SIG_ABSENT)
            begin
                cur_mode = hgd_pkg::MODE_NONE;
            end
            else if (cur_mode == hgd_pkg::MODE_FREE)
            begin
                cur_mode = hgd_pkg::MODE_ROT;
            end
            else
            begin
                cur_mode = hgd_pkg::MODE_FREE;
            end
            cmd = make_cmd(0, 0, 1'b1);
            return 1'b1;
        end

        ax = (held_x < 0) ? -held_x : held_x;
        az = (held_z < 0) ? -held_z : held_z;
        if (cur_mode == hgd_pkg::MODE_FREE)
        begin
            sdz = int'(side_dead);
            sfz = int'(side_full);
            lin = 1'b1;
            spd = shaped_speed(az, int'(fwd_dead), int'(fwd_full));
            ang = 0;
            if (ax >= sfz - EDGE_BAND)
            begin
                ang = 1;
                lin = 1'b0;
            end
            if (ax > sdz && ax < sfz)
            begin
                lin = 1'b0;
                ang = int'(top_angle) - (ax - sdz) / ANGLE_STEP;
            end
            if (held_z < 0)
            begin
                spd = -spd;
            end
            if (held_x < 0)
            begin
                ang = -ang;
            end
        end
        else
        begin
            lin = 1'b0;
            ang = 0;
            spd = shaped_speed(ax, int'(side_dead), int'(side_full));
            if (held_x < 0)
            begin
                spd = -spd;
            end
        end

        // Repeat filter: a new command restarts the count, a saturated count is silent.
        if (spd == last_speed && ang == last_angle)
        begin
            if (rep_count >= COUNT_MAX)
            begin
                return 1'b0;
            end
            rep_count++;
        end
        else
        begin
            last_speed = spd;
            last_angle = ang;
            rep_count  = 0;
        end
        if (rep_count == int'(rep_limit))
        begin
            cmd = make_cmd(spd, ang, lin);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Input driver: the model advances on every accepted frame.
    always @(posedge clk)
    begin : frame_driver
        drive_cmd_t cmd;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                frames_in++;
                if (map_frame(cur_frame, cmd))
                begin
                    expected_cmds.push_back(cmd);
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (frames_to_send.size() != 0 && !take_gap())
                begin
                    cur_frame = frames_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= hgd_pkg::S_TDATA_W'({cur_frame.palm_up, cur_frame.palm_z,
                                                     cur_frame.palm_x});
                    s_tuser  <= {cur_frame.right_seen, cur_frame.any_hand};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report(input string field, input int exp_val, input int act_val);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
    endtask

    // Result monitor: every command is compared with the oldest expected one.
    always @(posedge clk)
    begin : cmd_monitor
        drive_cmd_t got;
        drive_cmd_t exp_cmd;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(drive_cmd_t)-1:0];
                if (expected_cmds.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected command, expected none, actual %h",
                             $time, got);
                end
                else
                begin
                    exp_cmd = expected_cmds.pop_front();
                    cmds_checked++;
                    if (got.speed_cmd !== exp_cmd.speed_cmd)
                    begin
                        report("speed_cmd", exp_cmd.speed_cmd, $signed(got.speed_cmd));
                    end
                    if (got.angle_cmd !== exp_cmd.angle_cmd)
                    begin
                        report("angle_cmd", exp_cmd.angle_cmd, $signed(got.angle_cmd));
                    end
                    if (got.straight !== exp_cmd.straight)
                    begin
                        report("straight", exp_cmd.straight, got.straight);
                    end
                    if (got.mode_after !== exp_cmd.mode_after)
                    begin
                        report("mode_after", exp_cmd.mode_after, got.mode_after);
                    end
                end
            end
            m_tready <= !take_gap();
        end
    end

    // Watchdog on cycles in which no channel moves anything.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("simulation failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Called just after a rising edge; returns just after one.
    task automatic write_reg(input logic [hgd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hgd_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        apply_reg(idx, val);
        reg_writes++;
        @(posedge clk);
    endtask

    // Zone registers get random junk above bit 10, which must be dropped.
    task automatic set_regs(input int fd, input int ff, input int sd, input int sf,
                            input int ts, input int ta, input int rl);
        logic [JUNK_W-1:0] junk;
        junk = JUNK_W'($urandom);
        write_reg(hgd_pkg::REG_FWD_DEAD, {junk, fd[hgd_pkg::ZONE_W-1:0]});
        junk = JUNK_W'($urandom);
        write_reg(hgd_pkg::REG_FWD_FULL, {junk, ff[hgd_pkg::ZONE_W-1:0]});
        junk = JUNK_W'($urandom);
        write_reg(hgd_pkg::REG_SIDE_DEAD, {junk, sd[hgd_pkg::ZONE_W-1:0]});
        junk = JUNK_W'($urandom);
        write_reg(hgd_pkg::REG_SIDE_FULL, {junk, sf[hgd_pkg::ZONE_W-1:0]});
        junk = JUNK_W'($urandom);
        write_reg(hgd_pkg::REG_TOP_SPEED, {junk, ts[hgd_pkg::ZONE_W-1:0]});
        junk = JUNK_W'($urandom);
        write_reg(hgd_pkg::REG_TOP_ANGLE, {junk, ta[hgd_pkg::ZONE_W-1:0]});
        write_reg(hgd_pkg::REG_REPEAT, rl[hgd_pkg::REP_W-1:0]);
        settings_used++;
    endtask

    // Wait until every frame is in and every command out, then let the pipe empty.
    task automatic settle();
        int waited;
        while (frames_to_send.size() != 0 || s_tvalid)
        begin
            @(negedge clk);
        end
        waited = 0;
        while (expected_cmds.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic frame_t make_frame(input logic any_hand, input logic right_seen,
                                          input hgd_pkg::pos_t x, input hgd_pkg::pos_t z,
                                          input logic up);
        frame_t f;
        f.any_hand   = any_hand;
        f.right_seen = right_seen;
        f.palm_x     = x;
        f.palm_z     = z;
        f.palm_up    = up;
        return f;
    endfunction

    // Positions lean toward the zone edges, with extremes and full-range values.
    function automatic hgd_pkg::pos_t pick_pos();
        case ($urandom_range(9))
            0:       return POS_MIN;
            1:       return POS_MAX;
            2:       return '0;
            3, 4, 5, 6: return hgd_pkg::pos_t'($urandom_range(300) - 150);
            7, 8:    return hgd_pkg::pos_t'($urandom_range(60) - 30);
            default: return hgd_pkg::pos_t'($urandom);
        endcase
    endfunction

    // Mostly a steady right hand held for a few frames, some palm flips,
    // some frames without hands and some fully random frames.
    task automatic queue_random_frames(input int n);
        int            added;
        int            k;
        hgd_pkg::pos_t x, z;
        logic          up;
        logic [31:0]   raw;
        added = 0;
        while (added < n)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5:
                begin
                    x = pick_pos();
                    z = pick_pos();
                    up = 1'($urandom_range(1));
                    k = $urandom_range(1, 6);
                    repeat (k)
                    begin
                        if ($urandom_range(7) == 0)
                        begin
                            frames_to_send.push_back(make_frame(1'b1, 1'b0, pick_pos(),
                                                                pick_pos(),
                                                                1'($urandom_range(1))));
                        end
                        else
                        begin
                            frames_to_send.push_back(make_frame(1'b1, 1'b1, x, z, up));
                        end
                        added++;
                    end
                end
                6, 7:
                begin
                    frames_to_send.push_back(make_frame(1'b1, 1'b1, pick_pos(), pick_pos(), 1'b1));
                    frames_to_send.push_back(make_frame(1'b1, 1'b1, pick_pos(), pick_pos(), 1'b0));
                    added += 2;
                end
                8:
                begin
                    frames_to_send.push_back(make_frame(1'b0, 1'($urandom_range(1)), pick_pos(),
                                                        pick_pos(), 1'($urandom_range(1))));
                    added++;
                end
                default:
                begin
                    raw = $urandom;
                    frames_to_send.push_back(raw[$bits(frame_t)-1:0]);
                    added++;
                end
            endcase
        end
    endtask

    initial
    begin
        reset_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset settings: empty scene, left hand only,
        // start of free running, a repeat after ten unchanged commands, flips
        // both ways, a held hand in rotation and a right flag with no hands.
        frames_to_send.push_back(make_frame(1'b0, 1'b0, '0, '0, 1'b0));
        frames_to_send.push_back(make_frame(1'b1, 1'b0, POS_MAX, POS_MIN, 1'b1));
        frames_to_send.push_back(make_frame(1'b1, 1'b1, '0, '0, 1'b1));
        repeat (11) frames_to_send.push_back(make_frame(1'b1, 1'b1, hgd_pkg::pos_t'(50),
                                                        hgd_pkg::pos_t'(-77), 1'b1));
        frames_to_send.push_back(make_frame(1'b1, 1'b1, hgd_pkg::pos_t'(50),
                                            hgd_pkg::pos_t'(-77), 1'b0));
        frames_to_send.push_back(make_frame(1'b1, 1'b1, POS_MIN, '0, 1'b0));
        frames_to_send.push_back(make_frame(1'b1, 1'b0, '0, '0, 1'b0));
        frames_to_send.push_back(make_frame(1'b1, 1'b1, POS_MAX, POS_MAX, 1'b1));
        frames_to_send.push_back(make_frame(1'b1, 1'b1, POS_MAX, POS_MAX, 1'b0));
        frames_to_send.push_back(make_frame(1'b0, 1'b1, '0, '0, 1'b1));
        settle();

        // The unused index must leave every register alone.
        write_reg(REG_UNUSED, hgd_pkg::CFG_DATA_W'($urandom));

        // Reset zones with every changed command sent.
        set_regs(20, 120, 20, 120, 100, 10, 0);
        queue_random_frames(110);
        settle();

        // Narrow random zones with short repeat counts.
        set_regs($urandom_range(60), $urandom_range(40, 250), $urandom_range(60),
                 $urandom_range(250), $urandom_range(2047), $urandom_range(40),
                 $urandom_range(1, 3));
        queue_random_frames(110);
        settle();

        // All zones and magnitudes at zero.
        set_regs(0, 0, 0, 0, 0, 0, 0);
        queue_random_frames(100);
        settle();

        // Zones and magnitudes at full scale, without any idle cycles.
        no_gaps = 1'b1;
        set_regs(2047, 2047, 2047, 2047, 2047, 2047, 2);
        queue_random_frames(100);
        settle();
        no_gaps = 1'b0;

        // Side full zone below the edge band, and rotation speeds that go negative.
        set_regs(2047, 2047, 0, 1, 2047, 2047, 0);
        queue_random_frames(100);
        settle();

        set_regs($urandom_range(200), $urandom_range(400), $urandom_range(200),
                 $urandom_range(400), $urandom_range(2047), $urandom_range(60),
                 $urandom_range(4));
        queue_random_frames(100);
        settle();

        set_regs($urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
                 $urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
                 $urandom_range(4));
        queue_random_frames(100);
        settle();

        while (expected_cmds.size() != 0)
        begin
            drive_cmd_t left_cmd;
            left_cmd = expected_cmds.pop_front();
            errors++;
            $display("%0t: command never sent, expected %h, actual none", $time, left_cmd);
        end

        $display("Checked %0d drive commands from %0d frames.", cmds_checked, frames_in);
        $display("Used %0d register settings in %0d writes, zero to full scale.",
                 settings_used, reg_writes);
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/hgd_pkg.sv
design/hand_gesture_drive_mapper.sv
dv/hand_gesture_drive_mapper_tb.sv
